[src/flpw_pkg.sv]
package flpw_pkg;

  localparam int unsigned VA_W      = 48;
  localparam int unsigned ENTRY_W   = 64;
  localparam int unsigned HOST_W    = 64;
  localparam int unsigned PA_W      = 52;
  localparam int unsigned LEVEL_W   = 2;
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_W     = 64;

  // guest physical memory above the hole lands 2 GiB lower in host space
  localparam logic [PA_W-1:0] HOLE_SIZE = PA_W'(64'h0000_0000_8000_0000);

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_ROOT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HOST_BASE  = CFG_IDX_W'(1);

  localparam logic [LEVEL_W-1:0] LVL_TOP     = LEVEL_W'(0);
  localparam logic [LEVEL_W-1:0] LVL_LARGE   = LEVEL_W'(2);
  localparam logic [LEVEL_W-1:0] LVL_LEAF    = LEVEL_W'(3);

  localparam int unsigned PRESENT_BIT   = 0;
  localparam int unsigned PAGE_SIZE_BIT = 7;

  typedef enum logic {
    FUNC_TRANSLATE = 1'b0,
    FUNC_ENTRY     = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    KIND_READ        = 2'd0,
    KIND_DONE        = 2'd1,
    KIND_NOT_PRESENT = 2'd2,
    KIND_HOLE        = 2'd3
  } kind_t;

  typedef struct packed {
    func_t              func;
    logic [VA_W-1:0]    virt_addr;
    logic [ENTRY_W-1:0] entry_data;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [HOST_W-1:0]  host_address;
    logic [PA_W-1:0]    phys_addr;
    logic [LEVEL_W-1:0] walk_level;
  } out_item_t;

endpackage

[src/four_level_page_walker.sv]
// four-level page table walker, 4 KiB pages and 2 MiB large pages
//
// in channel: one transfer per item. func translate latches a 48-bit virtual
// address and starts a walk; func entry hands back the page table entry that
// the last read request asked for. A request while a walk is running and an
// entry while idle are dropped and give no result.
// out channel: at most one result per item: an entry read request with its
// host address, a finished translation, a not present fault or a hole fault.
// cfg channel: writes table_root (index 0) and host_base (index 1); other
// indexes are ignored. cfg_ready is always high; write only while idle.
// a result is registered in the output register, or in the skid register when
// the receiver stalls. throughput: one item per cycle while in_stall is low, set
// by the output register fed straight from the entry decode and the 64-bit add.
// when the receiver stalls, a second result is caught in a skid register and
// in_stall rises only while that skid register is full.
// reset: walker idle, level and held address zero, both config registers
// zero, no result pending.
module four_level_page_walker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  flpw_pkg::in_item_t        in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output flpw_pkg::out_item_t       out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [flpw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [flpw_pkg::CFG_W-1:0]     cfg_data
);
  import flpw_pkg::*;

  // config registers
  logic [CFG_W-1:0]   table_root_r;
  logic [CFG_W-1:0]   host_base_r;

  // walk state
  logic               busy_r,  busy_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [VA_W-1:0]    held_r,  held_nxt;

  // output register and skid register
  logic               out_valid_r,  out_valid_nxt;
  out_item_t          out_data_r,   out_data_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  out_item_t          skid_data_r,  skid_data_nxt;

  logic               accept;
  logic               drain;
  logic               res_valid;
  out_item_t          res;

  // entry read issue path
  logic               is_translate;
  logic [LEVEL_W-1:0] issue_lvl;
  logic [ENTRY_W-1:0] issue_table;
  logic [VA_W-1:0]    issue_va;
  logic [IDX_W-1:0]   issue_idx;
  logic [PA_W-1:0]    entry_addr;
  logic [PA_W-1:0]    mapped_addr;
  logic               addr_low;
  logic               addr_high;
  out_item_t          issue_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !skid_valid_r;
  assign drain     = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // entry address for the next read: table frame plus eight times the index
  always_comb begin
    is_translate = (in_data.func == FUNC_TRANSLATE);
    issue_lvl    = is_translate ? LVL_TOP : level_r + LEVEL_W'(1);
    issue_table  = is_translate ? table_root_r : in_data.entry_data;
    issue_va     = is_translate ? in_data.virt_addr : held_r;
    case (issue_lvl)
      2'd0:    issue_idx = issue_va[47:39];
      2'd1:    issue_idx = issue_va[38:30];
      2'd2:    issue_idx = issue_va[29:21];
      2'd3:    issue_idx = issue_va[20:12];
      default: issue_idx = issue_va[47:39];
    endcase
    // frame and index do not overlap, so no carry
    entry_addr  = {issue_table[51:12], issue_idx, 3'b000};
    // below 2 GiB maps straight, at 4 GiB and up sits 2 GiB lower
    addr_low    = (entry_addr[PA_W-1:31] == '0);
    addr_high   = |entry_addr[PA_W-1:32];
    mapped_addr = addr_high ? entry_addr - HOLE_SIZE : entry_addr;

    issue_res                  = '0;
    issue_res.walk_level       = issue_lvl;
    if (addr_low || addr_high) begin
      issue_res.kind         = KIND_READ;
      issue_res.host_address = host_base_r + {{(HOST_W-PA_W){1'b0}}, mapped_addr};
    end else begin
      issue_res.kind         = KIND_HOLE;
    end
  end

  // walk step
  always_comb begin
    busy_nxt  = busy_r;
    level_nxt = level_r;
    held_nxt  = held_r;
    res_valid = 1'b0;
    res       = '0;
    if (accept) begin
      if (is_translate) begin
        if (!busy_r) begin
          held_nxt  = in_data.virt_addr;
          level_nxt = LVL_TOP;
          res_valid = 1'b1;
          res       = issue_res;
          busy_nxt  = (issue_res.kind == KIND_READ);
        end
      end else if (busy_r) begin
        res_valid = 1'b1;
        if (!in_data.entry_data[PRESENT_BIT]) begin
          res.kind       = KIND_NOT_PRESENT;
          res.walk_level = level_r;
          busy_nxt       = 1'b0;
        end else if (level_r == LVL_LARGE && in_data.entry_data[PAGE_SIZE_BIT]) begin
          // 2 MiB page
          res.kind       = KIND_DONE;
          res.walk_level = LVL_LARGE;
          res.phys_addr  = {in_data.entry_data[51:21], held_r[20:0]};
          busy_nxt       = 1'b0;
        end else if (level_r == LVL_LEAF) begin
          // 4 KiB page
          res.kind       = KIND_DONE;
          res.walk_level = LVL_LEAF;
          res.phys_addr  = {in_data.entry_data[51:12], held_r[11:0]};
          busy_nxt       = 1'b0;
        end else begin
          res = issue_res;
          if (issue_res.kind == KIND_READ) begin
            level_nxt = issue_lvl;
          end else begin
            busy_nxt = 1'b0;
          end
        end
      end
    end
  end

  // output register with skid: a result arriving behind a stalled one waits
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (drain) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || drain) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else if (drain) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_root_r <= '0;
      host_base_r  <= '0;
      busy_r       <= 1'b0;
      level_r      <= '0;
      held_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TABLE_ROOT: table_root_r <= cfg_data;
          REG_HOST_BASE:  host_base_r  <= cfg_data;
          default: ;
        endcase
      end
      busy_r       <= busy_nxt;
      level_r      <= level_nxt;
      held_r       <= held_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule
